### src/project_point_bilinear_neighbours_top_defines.svh
// assertion helpers for the projection block
`ifndef PROJECT_POINT_BILINEAR_NEIGHBOURS_TOP_DEFINES_SVH
`define PROJECT_POINT_BILINEAR_NEIGHBOURS_TOP_DEFINES_SVH

// same-cycle implication
`define PPBN_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ppbn assertion failed");

// next-cycle implication
`define PPBN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ppbn assertion failed");

`endif

### src/ppbn_pkg.sv
package ppbn_pkg;

  localparam int GRID_ADDR_BITS_DEF = 19;
  localparam int SCREEN_WIDTH_DEF   = 640;
  localparam int SCREEN_HEIGHT_DEF  = 480;

  localparam logic [1:0] MODE_CELL  = 2'd0;
  localparam logic [1:0] MODE_COEF  = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  localparam logic [1:0] REG_U_MAX = 2'd0;
  localparam logic [1:0] REG_V_MAX = 2'd1;
  localparam logic [1:0] REG_U_MIN = 2'd2;
  localparam logic [1:0] REG_V_MIN = 2'd3;

  localparam int NUM_TERMS = 9;
  localparam int ACC_W     = 58;
  localparam int NUM_W     = ACC_W + 1;
  localparam int INT_BITS  = 7;
  localparam int FRAC_BITS = 32;
  localparam int QUO_W     = INT_BITS + FRAC_BITS;
  localparam int MAG_W     = QUO_W + 1;

  typedef struct packed {
    logic [9:0]  u;
    logic [9:0]  v;
    logic [16:0] weight;
    logic        in_range;
    logic        complete;
    logic        last;
  } res_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [NUM_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [MAG_W-1:0] mag;
  } div_rsp_t;

endpackage

### src/ppbn_div.sv
module ppbn_div
  import ppbn_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int R_W   = NUM_W + 1;
  localparam int DSH_W = NUM_W + INT_BITS - 1;
  localparam int CMP_W = DSH_W;

  typedef enum logic {D_IDLE, D_RUN} dstate_t;

  dstate_t          state;
  logic [R_W-1:0]   r;
  logic [NUM_W-1:0] dm;
  logic [DSH_W-1:0] dsh;
  logic [QUO_W-1:0] q;
  logic [5:0]       step;
  logic             sat;
  logic             done;

  logic             frac;
  logic [R_W-1:0]   a;
  logic [CMP_W-1:0] b;
  logic             ge;

  assign frac = step >= 6'(INT_BITS);
  assign a    = frac ? {r[R_W-2:0], 1'b0} : r;
  assign b    = frac ? CMP_W'(dm) : dsh;
  assign ge   = CMP_W'(a) >= b;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        D_IDLE: begin
          if (req.start) begin
            r     <= R_W'(req.num);
            dm    <= req.den;
            dsh   <= {req.den, (INT_BITS-1)'(0)};
            sat   <= {INT_BITS'(0), req.num} >= {req.den, INT_BITS'(0)};
            step  <= '0;
            state <= D_RUN;
          end
        end
        D_RUN: begin
          r    <= ge ? R_W'(CMP_W'(a) - b) : a;
          q    <= {q[QUO_W-2:0], ge};
          dsh  <= dsh >> 1;
          step <= step + 6'd1;
          if (step == 6'(QUO_W - 1)) begin
            done  <= 1'b1;
            state <= D_IDLE;
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end

  assign rsp.busy = state == D_RUN;
  assign rsp.done = done;
  assign rsp.mag  = sat ? {1'b1, QUO_W'(0)} : {1'b0, q};

endmodule

### src/project_point_bilinear_neighbours_top.sv
// a query forms nine products, runs two 39-step divisions, then does one
// memory read for each neighbour tried
// one item is buffered while the engine works
// throughput is set by the shared divider and the single grid memory port
// reset: synchronous; afterwards the grid memory is cleared one entry a
// cycle over all 2**GRID_ADDR_BITS entries and no item is taken until it is done
`include "project_point_bilinear_neighbours_top_defines.svh"

module project_point_bilinear_neighbours_top
  import ppbn_pkg::*;
#(
  parameter int GRID_ADDR_BITS = GRID_ADDR_BITS_DEF,
  parameter int SCREEN_WIDTH   = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT  = SCREEN_HEIGHT_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [9:0]   cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  // cell_u, cell_v, coef_index, coef_value, point_x, point_y, point_z
  input  logic [151:0] s_tdata,
  // mode
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // neighbour_u, neighbour_v, weight, in_range, complete, zero pad
  output logic [39:0]  m_tdata,
  output logic         m_tlast
);

  localparam int GRID_DEPTH = 2 ** GRID_ADDR_BITS;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_CHKW, ST_DIV, ST_SCALE, ST_BOUND, ST_NEXT, ST_RD, ST_CHK,
    ST_FLUSH
  } state_t;

  state_t state;

  logic [9:0] u_max, v_max, u_min, v_min;

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      u_max <= 10'd639;
      v_max <= 10'd479;
      u_min <= 10'd0;
      v_min <= 10'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_U_MAX: u_max <= cfg_data;
        REG_V_MAX: v_max <= cfg_data;
        REG_U_MIN: u_min <= cfg_data;
        REG_V_MIN: v_min <= cfg_data;
        default: ;
      endcase
    end
  end

  // input buffer
  logic         buf_valid;
  logic [1:0]   buf_mode;
  logic [151:0] buf_data;
  logic         clearing;
  logic [GRID_ADDR_BITS:0] clr_cnt;
  logic         take;

  assign s_tready = !buf_valid && !clearing;
  assign take     = state == ST_IDLE && buf_valid && !clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      buf_valid <= 1'b1;
      buf_mode  <= s_tuser;
      buf_data  <= s_tdata;
    end else if (take) begin
      buf_valid <= 1'b0;
    end
  end

  logic [9:0]  b_cell_u, b_cell_v;
  logic [3:0]  b_coef_idx;
  logic [31:0] b_coef_val;
  assign b_cell_u   = buf_data[9:0];
  assign b_cell_v   = buf_data[19:10];
  assign b_coef_idx = buf_data[23:20];
  assign b_coef_val = buf_data[55:24];

  // grid memory
  logic [20:0] grid [GRID_DEPTH];
  logic        mem_we;
  logic [GRID_ADDR_BITS-1:0] mem_wa, maddr;
  logic [20:0] mem_wd, mem_q;

  logic [9:0]  x, y, addr_u, addr_v;
  logic [1:0]  cidx;
  logic [10:0] pitch;
  logic [20:0] vp;
  logic [21:0] addr_full;
  logic [GRID_ADDR_BITS-1:0] gaddr;

  assign addr_u    = (state == ST_IDLE) ? b_cell_u : (x + 10'(cidx != 2'd0));
  assign addr_v    = (state == ST_IDLE) ? b_cell_v : (y + 10'(cidx != 2'd1));
  assign pitch     = {1'b0, u_max} + 11'd1;
  assign vp        = addr_v * pitch;
  assign addr_full = {1'b0, vp} + {12'd0, addr_u};
  assign gaddr     = addr_full[GRID_ADDR_BITS-1:0];

  assign mem_we = clearing || (take && buf_mode == MODE_CELL);
  assign mem_wa = clearing ? clr_cnt[GRID_ADDR_BITS-1:0] : gaddr;
  assign mem_wd = clearing ? 21'd0 : {1'b1, b_cell_v, b_cell_u};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid[mem_wa] <= mem_wd;
    end
    if (state == ST_RD) begin
      mem_q <= grid[maddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == (GRID_ADDR_BITS+1)'(GRID_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // projection terms and accumulators
  logic signed [31:0] terms [NUM_TERMS];
  logic signed [31:0] pnt [3];
  logic [3:0]  mcnt;
  logic [1:0]  col, row, prow;
  logic        prod_v;
  logic signed [63:0] prod;
  logic signed [ACC_W-1:0] acc [3];

  logic signed [ACC_W-1:0] xs, ys, ws;
  assign xs = acc[0];
  assign ys = acc[1];
  assign ws = acc[2];

  logic [NUM_W-1:0] n_u, n_v, d2w, n_sel, n_mag, d_mag;
  assign n_u   = {xs[ACC_W-1], xs} + {ws[ACC_W-1], ws};
  assign n_v   = {ws[ACC_W-1], ws} - {ys[ACC_W-1], ys};
  assign d2w   = {ws, 1'b0};
  assign n_sel = (state == ST_CHKW) ? n_u : n_v;
  assign n_mag = n_sel[NUM_W-1] ? (NUM_W)'(-n_sel) : n_sel;
  assign d_mag = d2w[NUM_W-1] ? (NUM_W)'(-d2w) : d2w;

  div_req_t div_req;
  div_rsp_t div_rsp;
  logic     second;
  logic     neg;

  assign div_req.start = (state == ST_CHKW && ws != '0) || (state == ST_SCALE && !second);
  assign div_req.num   = n_mag;
  assign div_req.den   = d_mag;

  ppbn_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  logic signed [MAG_W:0]  ratio;
  logic signed [11:0]     scr;
  logic signed [MAG_W+12:0] ps, uq, vq;
  assign ratio = neg ? -$signed({1'b0, div_rsp.mag}) : $signed({1'b0, div_rsp.mag});
  assign scr   = second ? 12'(SCREEN_HEIGHT) : 12'(SCREEN_WIDTH);

  localparam int P_W = MAG_W + 13;
  logic signed [P_W-33:0] xi, yi;
  assign xi = uq[P_W-1:32];
  assign yi = vq[P_W-1:32];

  logic out_of_range;
  assign out_of_range = xi > $signed((P_W-32)'(u_max)) || xi < $signed((P_W-32)'(u_min)) ||
                        yi > $signed((P_W-32)'(v_max)) || yi < $signed((P_W-32)'(v_min));

  logic [15:0] fu, fv, cu, cv, wa, wb;
  logic [31:0] wprod;
  logic [2:0]  mask;
  logic [2:0]  nres;
  res_t        pend, out_r;
  logic        out_valid, out_free;

  assign cu = 16'(-fu);
  assign cv = 16'(-fv);
  always_comb begin
    case (cidx)
      2'd0:    begin wa = fu; wb = cv; end
      2'd1:    begin wa = cu; wb = fv; end
      default: begin wa = cu; wb = cv; end
    endcase
    if (state == ST_BOUND) begin
      wa = uq[31:16];
      wb = vq[31:16];
    end
  end
  assign wprod = wa * wb;

  assign out_free = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      prod_v    <= 1'b0;
      for (int i = 0; i < NUM_TERMS; i++) begin
        terms[i] <= '0;
      end
    end else begin
      if (m_tready) begin
        out_valid <= 1'b0;
      end
      if (prod_v) begin
        acc[prow] <= acc[prow] + {{2{prod[63]}}, prod[63:8]};
      end
      case (state)
        ST_IDLE: begin
          if (take) begin
            case (buf_mode)
              MODE_COEF: begin
                if (b_coef_idx < 4'(NUM_TERMS)) begin
                  terms[b_coef_idx] <= b_coef_val;
                end
              end
              MODE_QUERY: begin
                pnt[0] <= buf_data[87:56];
                pnt[1] <= buf_data[119:88];
                pnt[2] <= buf_data[151:120];
                for (int i = 0; i < 3; i++) begin
                  acc[i] <= '0;
                end
                mcnt  <= '0;
                col   <= '0;
                row   <= '0;
                state <= ST_MUL;
              end
              default: ;
            endcase
          end
        end
        ST_MUL: begin
          if (mcnt != 4'(NUM_TERMS)) begin
            prod   <= terms[mcnt] * pnt[col];
            prow   <= row;
            prod_v <= 1'b1;
            mcnt   <= mcnt + 4'd1;
            col    <= (col == 2'd2) ? 2'd0 : col + 2'd1;
            row    <= (col == 2'd2) ? row + 2'd1 : row;
          end else begin
            prod_v <= 1'b0;
            state  <= ST_CHKW;
          end
        end
        ST_CHKW: begin
          second <= 1'b0;
          if (ws == '0) begin
            pend  <= '{u: '0, v: '0, weight: '0, in_range: 1'b0, complete: 1'b0, last: 1'b1};
            state <= ST_FLUSH;
          end else begin
            neg   <= n_sel[NUM_W-1] ^ ws[ACC_W-1];
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            ps    <= ratio * scr;
            state <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          if (!second) begin
            uq     <= ps;
            neg    <= n_sel[NUM_W-1] ^ ws[ACC_W-1];
            second <= 1'b1;
            state  <= ST_DIV;
          end else begin
            vq    <= ps;
            state <= ST_BOUND;
          end
        end
        ST_BOUND: begin
          if (out_of_range) begin
            pend  <= '{u: '0, v: '0, weight: '0, in_range: 1'b0, complete: 1'b0, last: 1'b1};
            state <= ST_FLUSH;
          end else begin
            x    <= xi[9:0];
            y    <= yi[9:0];
            fu   <= uq[31:16];
            fv   <= vq[31:16];
            mask <= {xi[9:0] != u_max && yi[9:0] != v_max, xi[9:0] != u_max,
                     yi[9:0] != v_max};
            pend <= '{u: xi[9:0], v: yi[9:0], weight: {1'b0, wprod[31:16]},
                      in_range: 1'b1, complete: 1'b0, last: 1'b0};
            nres  <= 3'd1;
            cidx  <= 2'd0;
            state <= ST_NEXT;
          end
        end
        ST_NEXT: begin
          if (cidx == 2'd3) begin
            pend.last     <= 1'b1;
            pend.complete <= nres == 3'd4;
            state         <= ST_FLUSH;
          end else if (mask[cidx]) begin
            maddr <= gaddr;
            state <= ST_RD;
          end else begin
            cidx <= cidx + 2'd1;
          end
        end
        ST_RD: begin
          state <= ST_CHK;
        end
        ST_CHK: begin
          if (!mem_q[20]) begin
            cidx  <= cidx + 2'd1;
            state <= ST_NEXT;
          end else if (out_free) begin
            out_r     <= pend;
            out_valid <= 1'b1;
            pend      <= '{u: mem_q[9:0], v: mem_q[19:10], weight: {1'b0, wprod[31:16]},
                           in_range: 1'b1, complete: 1'b0, last: 1'b0};
            nres      <= nres + 3'd1;
            cidx      <= cidx + 2'd1;
            state     <= ST_NEXT;
          end
        end
        ST_FLUSH: begin
          if (out_free) begin
            out_r     <= pend;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_r.complete, out_r.in_range, out_r.weight, out_r.v, out_r.u};
  assign m_tlast  = out_r.last;

  `PPBN_ASSERT(a_no_out_while_clear, clearing, !m_tvalid)
  `PPBN_ASSERT(a_complete_is_last, m_tvalid && out_r.complete, m_tlast)
  `PPBN_ASSERT(a_reject_empty, m_tvalid && !out_r.in_range, m_tlast && out_r.weight == '0)
  `PPBN_ASSERT_NEXT(a_div_done_pulse, div_rsp.done, !div_rsp.done)

endmodule

### verif/tb.sv
`timescale 1ns / 100ps

module tb;
  import ppbn_pkg::*;

  localparam int WATCHDOG_LIMIT = 1600000;
  localparam int SETTLE_CYCLES  = 150;
  localparam int HOLD_CYCLES    = 2500;
  localparam int TARGET_ITEMS   = 480;

  typedef struct {
    logic [1:0]  mode;
    logic [9:0]  cu;
    logic [9:0]  cv;
    logic [3:0]  ci;
    logic [31:0] cval;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    bit          known_reject;
  } stim_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_index = '0;
  logic [9:0]   cfg_data = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [151:0] s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [39:0]  m_tdata;
  logic         m_tlast;

  project_point_bilinear_neighbours_top dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [31:0] proj_terms [NUM_TERMS];
  logic [20:0] grid_mem [int unsigned];
  int unsigned u_max = 639, v_max = 479, u_min = 0, v_min = 0;

  res_t neighbour_q[$];
  int   n_items, n_results, n_queries, n_rejects, n_full, n_errors;
  bit   calm;

  function automatic int unsigned grid_addr(int unsigned u, int unsigned v);
    return (u + v * (u_max + 1)) & ((1 << GRID_ADDR_BITS_DEF) - 1);
  endfunction

  function automatic longint ratio_q32(longint n, longint d);
    longint unsigned nm, dm, q, r, mag;
    nm = (n < 0) ? longint'(0) - n : n;
    dm = (d < 0) ? longint'(0) - d : d;
    q = nm / dm;
    r = nm % dm;
    if (q >= 128) begin
      mag = 64'd128 << 32;
    end else begin
      mag = q;
      for (int i = 0; i < 32; i++) begin
        r = r << 1;
        mag = mag << 1;
        if (r >= dm) begin
          r = r - dm;
          mag = mag | 64'd1;
        end
      end
    end
    return ((n < 0) != (d < 0)) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint proj_row(int row, longint p[3]);
    longint acc;
    acc = 0;
    for (int c = 0; c < 3; c++)
      acc += (longint'($signed(proj_terms[row * 3 + c])) * p[c]) >>> 8;
    return acc;
  endfunction

  function automatic res_t reject_res();
    res_t r;
    r = '0;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic void try_neighbour(ref res_t q[$], input int unsigned u,
                                        input int unsigned v, input longint w);
    logic [20:0] e;
    res_t r;
    int unsigned a;
    a = grid_addr(u, v);
    if (!grid_mem.exists(a)) return;
    e = grid_mem[a];
    r = '0;
    r.u = e[9:0];
    r.v = e[19:10];
    r.weight = w[16:0];
    r.in_range = 1'b1;
    q.push_back(r);
  endfunction

  function automatic void predict_neighbours(stim_t s);
    longint p[3];
    longint xs, ys, ws, uq, vq, xi, yi, fu, fv, cu, cv;
    res_t found[$];
    res_t r;
    int unsigned x, y;
    case (s.mode)
      MODE_CELL: grid_mem[grid_addr(s.cu, s.cv)] = {1'b1, s.cv, s.cu};
      MODE_COEF: if (s.ci <= 8) proj_terms[s.ci] = s.cval;
      MODE_QUERY: begin
        n_queries++;
        p[0] = longint'($signed(s.px));
        p[1] = longint'($signed(s.py));
        p[2] = longint'($signed(s.pz));
        xs = proj_row(0, p);
        ys = proj_row(1, p);
        ws = proj_row(2, p);
        if (ws == 0) begin
          neighbour_q.push_back(reject_res());
          n_rejects++;
          return;
        end
        uq = (longint'(SCREEN_WIDTH_DEF) * ratio_q32(xs + ws, 2 * ws)) >>> 16;
        vq = (longint'(SCREEN_HEIGHT_DEF) * ratio_q32(ws - ys, 2 * ws)) >>> 16;
        xi = uq >>> 16;
        yi = vq >>> 16;
        if (xi > longint'(u_max) || xi < longint'(u_min) ||
            yi > longint'(v_max) || yi < longint'(v_min)) begin
          neighbour_q.push_back(reject_res());
          n_rejects++;
          return;
        end
        x = xi;
        y = yi;
        fu = uq & 64'hFFFF;
        fv = vq & 64'hFFFF;
        cu = (fu != 0) ? 65536 - fu : 0;
        cv = (fv != 0) ? 65536 - fv : 0;
        r = '0;
        r.u = x[9:0];
        r.v = y[9:0];
        r.weight = 17'((fu * fv) >> 16);
        r.in_range = 1'b1;
        found.push_back(r);
        if (x == u_max && y != v_max) begin
          try_neighbour(found, x, y + 1, (fu * cv) >> 16);
        end else if (y == v_max && x != u_max) begin
          try_neighbour(found, x + 1, y, (cu * fv) >> 16);
        end else if (x != u_max && y != v_max) begin
          try_neighbour(found, x, y + 1, (fu * cv) >> 16);
          try_neighbour(found, x + 1, y, (cu * fv) >> 16);
          try_neighbour(found, x + 1, y + 1, (cu * cv) >> 16);
        end
        found[found.size() - 1].last = 1'b1;
        found[found.size() - 1].complete = (found.size() == 4);
        if (found.size() == 4) n_full++;
        foreach (found[i]) neighbour_q.push_back(found[i]);
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(stim_t s);
    while (!calm && $urandom_range(0, 99) < 36) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= s.mode;
    s_tdata <= {s.pz, s.py, s.px, s.cval, s.ci, s.cv, s.cu};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n_items++;
    if (s.known_reject) begin
      neighbour_q.push_back(reject_res());
      n_queries++;
      n_rejects++;
    end else begin
      predict_neighbours(s);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (neighbour_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_bounds(int unsigned umx, int unsigned vmx, int unsigned umn,
                              int unsigned vmn);
    logic [1:0] idx [4];
    int unsigned val [4];
    idx = '{REG_U_MAX, REG_V_MAX, REG_U_MIN, REG_V_MIN};
    val = '{umx, vmx, umn, vmn};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i][9:0];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    u_max = umx;
    v_max = vmx;
    u_min = umn;
    v_min = vmn;
  endtask

  function automatic stim_t mk(logic [1:0] mode, logic [9:0] cu, logic [9:0] cv,
                               logic [3:0] ci, logic [31:0] cval, logic [31:0] px,
                               logic [31:0] py, logic [31:0] pz, bit rej);
    stim_t s;
    s.mode = mode; s.cu = cu; s.cv = cv; s.ci = ci; s.cval = cval;
    s.px = px; s.py = py; s.pz = pz; s.known_reject = rej;
    return s;
  endfunction

  function automatic stim_t rand_item(logic [1:0] mode);
    return mk(mode, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, 1'b0);
  endfunction

  // cells around a target pixel, then a query that lands on it
  task automatic send_patch();
    int unsigned ux, vx, tu, tv, f, g, k;
    int sx, px, py, pz;
    ux = (u_max < 639) ? u_max : 639;
    vx = (v_max < 479) ? v_max : 479;
    if (u_min > ux || v_min > vx) begin
      send_item(mk(MODE_QUERY, 0, 0, 0, 0, $urandom_range(0, 131072) - 65536,
                   $urandom_range(0, 131072) - 65536, 32'h10000, 1'b0));
      return;
    end
    case ($urandom_range(0, 4))
      0: tu = ux;
      1: tu = u_min;
      default: tu = $urandom_range(u_min, ux);
    endcase
    case ($urandom_range(0, 4))
      0: tv = vx;
      1: tv = v_min;
      default: tv = $urandom_range(v_min, vx);
    endcase
    for (int dv = 0; dv < 2; dv++)
      for (int du = 0; du < 2; du++)
        if ($urandom_range(0, 9) < 7)
          send_item(mk(MODE_CELL, 10'(tu + du), 10'(tv + dv), 0, 0, 0, 0, 0, 1'b0));
    f = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(0, 65535);
    g = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(0, 65535);
    k = $urandom_range(1, 100);
    sx = $urandom_range(0, 1) ? -1 : 1;
    px = ((tu * 65536 + f) / 320 - 65536) * k * sx;
    py = (65536 - (tv * 65536 + g) / 240) * k * sx;
    pz = 65536 * k * sx;
    send_item(mk(MODE_QUERY, 0, 0, 0, 0, px, py, pz, 1'b0));
  endtask

  task automatic send_noise();
    stim_t s;
    logic [3:0] ix;
    case ($urandom_range(0, 5))
      0: send_item(rand_item(MODE_CELL));
      1, 2: send_item(rand_item(MODE_QUERY));
      3: send_item(rand_item(2'd3));
      4: begin
        s = rand_item(MODE_COEF);
        s.ci = $urandom_range(9, 15);
        send_item(s);
      end
      default: begin
        ix = $urandom_range(0, 8);
        s = rand_item(MODE_COEF);
        s.ci = ix;
        send_item(s);
        if ($urandom_range(0, 1)) send_item(rand_item(MODE_QUERY));
        send_item(mk(MODE_COEF, 0, 0, ix, (ix % 4 == 0) ? 32'h0100_0000 : 32'h0,
                     0, 0, 0, 1'b0));
      end
    endcase
  endtask

  // receive and check
  int hold_left;
  bit held;
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      res_t e;
      n_results++;
      if (neighbour_q.size() == 0) begin
        $error("unexpected result u=%0d v=%0d", m_tdata[9:0], m_tdata[19:10]);
        n_errors++;
      end else begin
        e = neighbour_q.pop_front();
        if (m_tdata[9:0] !== e.u) begin
          $error("neighbour_u exp %0d got %0d", e.u, m_tdata[9:0]); n_errors++;
        end
        if (m_tdata[19:10] !== e.v) begin
          $error("neighbour_v exp %0d got %0d", e.v, m_tdata[19:10]); n_errors++;
        end
        if (m_tdata[36:20] !== e.weight) begin
          $error("weight exp %0d got %0d", e.weight, m_tdata[36:20]); n_errors++;
        end
        if (m_tdata[37] !== e.in_range) begin
          $error("in_range exp %0d got %0d", e.in_range, m_tdata[37]); n_errors++;
        end
        if (m_tdata[38] !== e.complete) begin
          $error("complete exp %0d got %0d", e.complete, m_tdata[38]); n_errors++;
        end
        if (m_tlast !== e.last) begin
          $error("last exp %0d got %0d", e.last, m_tlast); n_errors++;
        end
      end
    end
    if (!held && n_results == 60) begin
      held <= 1'b1;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm || ($urandom_range(0, 99) >= 36);
    end
  end

  int idle_cycles;
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("project_point_bilinear_neighbours_top verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    stim_t dir_tab[$];
    int unsigned bounds [5][4];
    for (int i = 0; i < NUM_TERMS; i++) proj_terms[i] = '0;
    bounds = '{'{639, 479, 0, 0}, '{1023, 1023, 0, 0}, '{100, 80, 50, 40},
               '{1023, 1023, 1023, 1023}, '{639, 479, 0, 0}};

    dir_tab.push_back(mk(MODE_QUERY, 0, 0, 0, 0, 32'h10000, 32'h10000, 32'h10000, 1'b1));
    dir_tab.push_back(mk(2'd3, 10'h3FF, 10'h3FF, 4'hF, '1, '1, '1, '1, 1'b0));
    dir_tab.push_back(mk(MODE_COEF, 0, 0, 4'd15, 32'h8000_0000, 0, 0, 0, 1'b0));
    dir_tab.push_back(mk(MODE_COEF, 0, 0, 4'd9, 32'hFFFF_FFFF, 0, 0, 0, 1'b0));
    dir_tab.push_back(mk(MODE_COEF, 0, 0, 4'd0, 32'h0100_0000, 0, 0, 0, 1'b0));
    dir_tab.push_back(mk(MODE_COEF, 0, 0, 4'd4, 32'h0100_0000, 0, 0, 0, 1'b0));
    dir_tab.push_back(mk(MODE_COEF, 0, 0, 4'd8, 32'h0100_0000, 0, 0, 0, 1'b0));
    dir_tab.push_back(mk(MODE_COEF, 0, 0, 4'd1, 32'h7FFF_FFFF, 0, 0, 0, 1'b0));
    dir_tab.push_back(mk(MODE_QUERY, 0, 0, 0, 0, 32'h0000_4000, 32'h0000_8000,
                         32'h10000, 1'b0));
    dir_tab.push_back(mk(MODE_COEF, 0, 0, 4'd1, 32'h0, 0, 0, 0, 1'b0));
    dir_tab.push_back(mk(MODE_COEF, 0, 0, 4'd2, 32'h8000_0000, 0, 0, 0, 1'b0));
    dir_tab.push_back(mk(MODE_COEF, 0, 0, 4'd2, 32'h0, 0, 0, 0, 1'b0));
    dir_tab.push_back(mk(MODE_CELL, 10'd0, 10'd0, 0, 0, 0, 0, 0, 1'b0));
    dir_tab.push_back(mk(MODE_CELL, 10'd1, 10'd0, 0, 0, 0, 0, 0, 1'b0));
    dir_tab.push_back(mk(MODE_CELL, 10'd0, 10'd1, 0, 0, 0, 0, 0, 1'b0));
    dir_tab.push_back(mk(MODE_CELL, 10'd1, 10'd1, 0, 0, 0, 0, 0, 1'b0));
    dir_tab.push_back(mk(MODE_CELL, 10'h3FF, 10'h3FF, 0, 0, 0, 0, 0, 1'b0));
    // top-left pixel, every neighbour present
    dir_tab.push_back(mk(MODE_QUERY, 0, 0, 0, 0, -32'sh10000, 32'h10000, 32'h10000, 1'b0));
    // bottom-right corner
    dir_tab.push_back(mk(MODE_QUERY, 0, 0, 0, 0, 32'h0000_FFFF, -32'sh0000_FFFF,
                         32'h10000, 1'b0));
    // zero third component
    dir_tab.push_back(mk(MODE_QUERY, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 1'b1));
    // far left, far right (saturated ratio)
    dir_tab.push_back(mk(MODE_QUERY, 0, 0, 0, 0, 32'h8000_0000, 0, 32'h10000, 1'b1));
    dir_tab.push_back(mk(MODE_QUERY, 0, 0, 0, 0, 32'h7FFF_FFFF, 0, 32'h10000, 1'b1));
    // negative depth
    dir_tab.push_back(mk(MODE_QUERY, 0, 0, 0, 0, 0, 0, -32'sh10000, 1'b0));

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) send_item(dir_tab[i]);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      write_bounds(bounds[ph][0], bounds[ph][1], bounds[ph][2], bounds[ph][3]);
      while (n_items < 25 + (ph + 1) * (TARGET_ITEMS - 25) / 5) begin
        calm = (ph == 2);
        if ($urandom_range(0, 9) < 7) send_patch();
        else send_noise();
      end
      calm = 1'b0;
      drain();
    end

    $display("items %0d, queries %0d (%0d rejected, %0d with four neighbours)",
             n_items, n_queries, n_rejects, n_full);
    $display("results checked %0d over five bound settings", n_results);
    if (n_errors == 0 && neighbour_q.size() == 0) begin
      $display("project_point_bilinear_neighbours_top verification clean");
    end else begin
      $display("project_point_bilinear_neighbours_top verification failed");
    end
    $finish;
  end

endmodule
